/* sv/tkcp_pkg.sv */
package tkcp_pkg;

	// default build parameters
	localparam int CHANNELS_DEF    = 8;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int IIR_SHIFT_DEF   = 2;
	localparam int NOISE_SHIFT_DEF = 3;
	localparam int DOWN_SHIFT_DEF  = 2;
	localparam int CAL_SHIFT_DEF   = 4;

	// fixed field widths
	localparam int CH_W     = 3;
	localparam int RAW_W    = 16;
	localparam int NOISE_W  = 8;
	localparam int CNT_W    = 8;
	localparam int MASK_W   = 8;
	localparam int TH_W     = 17;
	localparam int EV_W     = 3;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 88;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_THRESH_MIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UP_STEP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECAL_JUMP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_HYST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_IN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_OUT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STUCK_LIMIT  = 3'd6;

	localparam logic [15:0] THRESH_MIN_RST   = 16'd30;
	localparam logic [7:0]  UP_STEP_RST      = 8'd1;
	localparam logic [15:0] RECAL_JUMP_RST   = 16'd100;
	localparam logic [15:0] RELEASE_HYST_RST = 16'd10;
	localparam logic [7:0]  DEBOUNCE_IN_RST  = 8'd3;
	localparam logic [7:0]  DEBOUNCE_OUT_RST = 8'd3;
	localparam logic [7:0]  STUCK_LIMIT_RST  = 8'd200;

	// result event codes
	localparam logic [EV_W-1:0] EV_NORMAL = 3'd0;
	localparam logic [EV_W-1:0] EV_CALIB  = 3'd1;
	localparam logic [EV_W-1:0] EV_DONE   = 3'd2;
	localparam logic [EV_W-1:0] EV_JUMP   = 3'd3;
	localparam logic [EV_W-1:0] EV_STUCK  = 3'd4;
	localparam logic [EV_W-1:0] EV_REQ    = 3'd5;

endpackage

/* sv/tkcp_state_mem.sv */
module tkcp_state_mem import tkcp_pkg::*; #(
	parameter int             WIDTH   = 8,
	parameter int             DEPTH   = 8,
	parameter int             AW      = 3,
	parameter logic [WIDTH-1:0] RST_VAL = '0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// an entry never written reads as its reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : RST_VAL;

endmodule

/* sv/touch_key_channel_processor_top.sv */
// Channel | Direction | Beat contents
// s_axis  | in        | tuser: req_type; tdata: channel, raw_sample
// m_axis  | out       | tuser: event_code; tdata: channel, pressed, mask, baseline,
//         |           |        filtered, delta, noise, threshold
// cfg     | in        | cfg_wr_en / cfg_index / cfg_wdata, write only
//
// Four-stage pipeline around one channel-state memory (registered read), plus an output register.
// Different channels enter back to back, one beat per cycle while m_axis is not stalled.
// A beat for a channel still in the pipeline waits until that channel is written back.
// After reset every channel reads as reset state at once (per-entry valid bits).
// A stalled m_axis holds the output register; stages behind it fill before s_axis stalls.
module touch_key_channel_processor_top import tkcp_pkg::*; #(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int IIR_SHIFT   = IIR_SHIFT_DEF,
	parameter int NOISE_SHIFT = NOISE_SHIFT_DEF,
	parameter int DOWN_SHIFT  = DOWN_SHIFT_DEF,
	parameter int CAL_SHIFT   = CAL_SHIFT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_DATA_W-1:0]   s_axis_tdata,  // channel[2:0], raw_sample[18:3]
	input  logic [0:0]            s_axis_tuser,  // req_type[0]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_DATA_W-1:0]   m_axis_tdata,  // out_channel[2:0], key_pressed[3],
	                                             // pressed_mask[11:4], baseline_value[27:12],
	                                             // filtered_signal[43:28], touch_delta[59:44],
	                                             // noise_level[67:60], touch_threshold[84:68]
	output logic [EV_W-1:0]       m_axis_tuser,  // event_code[2:0]
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int SW  = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W;
	localparam int AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CSW = SW + CAL_SHIFT;
	localparam int CPW = CAL_SHIFT + 1;
	localparam int FNW = SW + IIR_SHIFT + 1;
	localparam int NW  = (((NOISE_W + NOISE_SHIFT) > SW) ? (NOISE_W + NOISE_SHIFT) : SW) + 1;
	localparam int UW  = ((SW > CNT_W) ? SW : CNT_W) + 1;

	typedef struct packed {
		logic [SW-1:0]      base;
		logic [SW-1:0]      sig;
		logic [NOISE_W-1:0] noise;
		logic [SW-1:0]      prv1;
		logic [SW-1:0]      prv2;
		logic [CNT_W-1:0]   deb;
		logic [CNT_W-1:0]   stuck;
		logic [CSW-1:0]     csum;
		logic [CPW-1:0]     cprog;
		logic               cal;
	} rec_t;

	localparam int REC_W = $bits(rec_t);
	localparam rec_t REC_RST = '{base: '0, sig: '0, noise: NOISE_W'(1), prv1: '0, prv2: '0,
		deb: '0, stuck: '0, csum: '0, cprog: '0, cal: 1'b1};

	typedef struct packed {
		logic               req;
		logic               inr;
		logic [CH_W-1:0]    ch;
		logic               pressed;
		rec_t               rec;
		logic [SW-1:0]      raw;
		logic [SW-1:0]      filt;
		logic [SW-1:0]      avg;
		logic [SW-1:0]      dold;
		logic [SW-1:0]      delta;
		logic [SW-1:0]      b_up;
		logic [SW-1:0]      b_dn;
		logic [SW-1:0]      dd;
		logic [CSW-1:0]     csum_n;
		logic [CPW-1:0]     cprog_n;
		logic               done;
		logic               jump;
		logic               quiet;
		logic               fge;
		logic [TH_W-1:0]    th0;
		logic [TH_W-1:0]    bj;
		logic [TH_W-1:0]    th;
		logic [TH_W-1:0]    th_done;
		logic [TH_W-1:0]    rel;
		logic [NOISE_W-1:0] noise_new;
		logic [CNT_W-1:0]   deb_inc;
		logic [CNT_W-1:0]   stuck_inc;
	} pipe_t;

	function automatic logic [SW-1:0] mid3(logic [SW-1:0] a, logic [SW-1:0] b, logic [SW-1:0] c);
		logic [SW-1:0] lo;
		logic [SW-1:0] hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c <= lo) return lo;
		if (c >= hi) return hi;
		return c;
	endfunction

	function automatic logic [TH_W-1:0] thresh(logic [15:0] tmin, logic [NOISE_W-1:0] n);
		return TH_W'(tmin) + TH_W'({n, 1'b0}) + TH_W'(n);
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
		return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
	endfunction

	// configuration registers
	logic [15:0] thresh_min_q, recal_jump_q, release_hyst_q;
	logic [7:0]  up_step_q, debounce_in_q, debounce_out_q, stuck_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_min_q   <= THRESH_MIN_RST;
			up_step_q      <= UP_STEP_RST;
			recal_jump_q   <= RECAL_JUMP_RST;
			release_hyst_q <= RELEASE_HYST_RST;
			debounce_in_q  <= DEBOUNCE_IN_RST;
			debounce_out_q <= DEBOUNCE_OUT_RST;
			stuck_limit_q  <= STUCK_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_THRESH_MIN:   thresh_min_q   <= cfg_wdata;
				REG_UP_STEP:      up_step_q      <= cfg_wdata[7:0];
				REG_RECAL_JUMP:   recal_jump_q   <= cfg_wdata;
				REG_RELEASE_HYST: release_hyst_q <= cfg_wdata;
				REG_DEBOUNCE_IN:  debounce_in_q  <= cfg_wdata[7:0];
				REG_DEBOUNCE_OUT: debounce_out_q <= cfg_wdata[7:0];
				REG_STUCK_LIMIT:  stuck_limit_q  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// input decode
	logic [CH_W-1:0] in_ch;
	logic            in_inr;
	logic            in_req;
	logic [SW-1:0]   in_raw;

	assign in_ch  = s_axis_tdata[CH_W-1:0];
	assign in_req = s_axis_tuser[0];
	assign in_raw = SW'(s_axis_tdata[CH_W +: RAW_W]);
	assign in_inr = {1'b0, in_ch} < (CH_W + 1)'(CHANNELS);

	// pipeline control
	pipe_t p_s1, p_s2, p_s3, p_s4;
	logic  v_s1, v_s2, v_s3, v_s4;
	logic  out_vld_q;
	logic  adv4, mv3, mv2, mv1, hazard, acc;

	assign adv4 = v_s4 && (!out_vld_q || m_axis_tready);
	assign mv3  = v_s3 && (!v_s4 || adv4);
	assign mv2  = v_s2 && (!v_s3 || mv3);
	assign mv1  = v_s1 && (!v_s2 || mv2);

	// same channel still in flight: wait for its write-back
	assign hazard = (v_s1 && p_s1.ch == in_ch) || (v_s2 && p_s2.ch == in_ch) ||
	                (v_s3 && p_s3.ch == in_ch) || (v_s4 && p_s4.ch == in_ch);

	assign s_axis_tready = (!v_s1 || mv1) && !hazard;
	assign acc           = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (acc) v_s1 <= 1'b1; else if (mv1) v_s1 <= 1'b0;
			if (mv1) v_s2 <= 1'b1; else if (mv2) v_s2 <= 1'b0;
			if (mv2) v_s3 <= 1'b1; else if (mv3) v_s3 <= 1'b0;
			if (mv3) v_s4 <= 1'b1; else if (adv4) v_s4 <= 1'b0;
			if (adv4) out_vld_q <= 1'b1; else if (m_axis_tready) out_vld_q <= 1'b0;
		end
	end

	// channel state memory and pressed flags
	rec_t          mem_rd;
	rec_t          wr_rec;
	logic          wr_en;
	logic [REC_W-1:0] mem_rd_bits;
	logic [CHANNELS-1:0] pressed_q;

	tkcp_state_mem #(
		.WIDTH   (REC_W),
		.DEPTH   (CHANNELS),
		.AW      (AW),
		.RST_VAL (REC_RST)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (p_s4.ch[AW-1:0]),
		.wr_data (wr_rec),
		.rd_en   (acc && in_inr),
		.rd_addr (in_ch[AW-1:0]),
		.rd_data (mem_rd_bits)
	);

	assign mem_rd = rec_t'(mem_rd_bits);

	pipe_t in_p;

	always_comb begin
		in_p         = '0;
		in_p.req     = in_req;
		in_p.inr     = in_inr;
		in_p.ch      = in_ch;
		in_p.raw     = in_raw;
		in_p.pressed = in_inr ? pressed_q[in_ch[AW-1:0]] : 1'b0;
	end

	always_ff @(posedge clk) begin
		if (acc) p_s1 <= in_p;
	end

	// stage 1: median, IIR, calibration sums, base threshold
	pipe_t n1;
	logic [SW-1:0]  med;
	logic [FNW-1:0] fnum;

	always_comb begin
		n1         = p_s1;
		n1.rec     = mem_rd;
		med        = mid3(mem_rd.prv1, mem_rd.prv2, p_s1.raw);
		fnum       = FNW'({mem_rd.sig, {IIR_SHIFT{1'b0}}}) - FNW'(mem_rd.sig) + FNW'(med);
		n1.filt    = SW'(fnum >> IIR_SHIFT);
		n1.csum_n  = mem_rd.csum + CSW'(p_s1.raw);
		n1.cprog_n = mem_rd.cprog + CPW'(1);
		n1.done    = n1.cprog_n[CPW-1];
		n1.avg     = SW'(n1.csum_n >> CAL_SHIFT);
		n1.th0     = thresh(thresh_min_q, mem_rd.noise);
		n1.bj      = TH_W'(mem_rd.base) + TH_W'(recal_jump_q);
		n1.dold    = (mem_rd.base > mem_rd.sig) ? mem_rd.base - mem_rd.sig : '0;
	end

	always_ff @(posedge clk) begin
		if (mv1) p_s2 <= n1;
	end

	// stage 2: delta and compares
	pipe_t n2;

	always_comb begin
		n2       = p_s2;
		n2.delta = (p_s2.rec.base > p_s2.filt) ? p_s2.rec.base - p_s2.filt : '0;
		n2.jump  = TH_W'(p_s2.filt) > p_s2.bj;
		n2.quiet = !p_s2.pressed && (TH_W'(n2.delta) < p_s2.th0);
		n2.fge   = p_s2.filt >= p_s2.rec.base;
	end

	always_ff @(posedge clk) begin
		if (mv2) p_s3 <= n2;
	end

	// stage 3: noise, thresholds, baseline candidates, counters
	pipe_t n3;
	logic [NW-1:0]    nsum;
	logic [NW-1:0]    nshr;
	logic [NOISE_W-1:0] nclamp;
	logic [UW-1:0]    bsum;
	logic [SW-1:0]    dsh;
	logic [SW-1:0]    bd;

	always_comb begin
		n3   = p_s3;
		nsum = NW'({p_s3.rec.noise, {NOISE_SHIFT{1'b0}}}) - NW'(p_s3.rec.noise) + NW'(p_s3.delta);
		nshr = nsum >> NOISE_SHIFT;
		if (nshr == '0) begin
			nclamp = NOISE_W'(1);
		end else if (nshr > NW'({NOISE_W{1'b1}})) begin
			nclamp = {NOISE_W{1'b1}};
		end else begin
			nclamp = nshr[NOISE_W-1:0];
		end
		n3.noise_new = p_s3.quiet ? nclamp : p_s3.rec.noise;
		n3.th        = thresh(thresh_min_q, n3.noise_new);
		n3.th_done   = thresh(thresh_min_q, NOISE_W'(1));
		n3.rel       = (p_s3.th0 > TH_W'(release_hyst_q)) ? p_s3.th0 - TH_W'(release_hyst_q)
		                                                   : TH_W'(thresh_min_q);
		bsum   = UW'(p_s3.rec.base) + UW'(up_step_q);
		n3.b_up = (bsum > UW'(p_s3.filt)) ? p_s3.filt : SW'(bsum);
		dsh    = p_s3.delta >> DOWN_SHIFT;
		if (dsh == '0) dsh = SW'(1);
		bd      = p_s3.rec.base - dsh;
		n3.b_dn = (bd < p_s3.filt) ? p_s3.filt : bd;
		n3.dd   = (p_s3.delta > dsh) ? p_s3.delta - dsh : '0;
		n3.deb_inc   = sat_inc(p_s3.rec.deb);
		n3.stuck_inc = sat_inc(p_s3.rec.stuck);
	end

	always_ff @(posedge clk) begin
		if (mv2 || mv3) begin
			if (mv3) p_s4 <= n3;
		end
	end

	// stage 4: decisions, write-back, result
	logic               pn;
	logic               lt;
	logic [EV_W-1:0]    ev;
	logic [SW-1:0]      o_base, o_sig, o_delta;
	logic [NOISE_W-1:0] o_noise;
	logic [TH_W-1:0]    o_th;
	logic [CHANNELS-1:0] pressed_nx;
	logic [M_DATA_W-1:0] od;

	always_comb begin
		wr_rec  = p_s4.rec;
		pn      = p_s4.pressed;
		lt      = TH_W'(p_s4.delta) < p_s4.th;
		ev      = EV_NORMAL;
		o_base  = p_s4.rec.base;
		o_sig   = p_s4.rec.sig;
		o_delta = p_s4.dold;
		o_noise = p_s4.rec.noise;
		o_th    = p_s4.th0;
		if (p_s4.req) begin
			wr_rec.deb   = '0;
			wr_rec.stuck = '0;
			wr_rec.csum  = '0;
			wr_rec.cprog = '0;
			wr_rec.cal   = 1'b1;
			pn = 1'b0;
			ev = EV_REQ;
		end else if (p_s4.rec.cal) begin
			if (p_s4.done) begin
				wr_rec.base  = p_s4.avg;
				wr_rec.sig   = p_s4.avg;
				wr_rec.prv1  = p_s4.avg;
				wr_rec.prv2  = p_s4.avg;
				wr_rec.noise = NOISE_W'(1);
				wr_rec.deb   = '0;
				wr_rec.stuck = '0;
				wr_rec.csum  = '0;
				wr_rec.cprog = '0;
				wr_rec.cal   = 1'b0;
				pn      = 1'b0;
				ev      = EV_DONE;
				o_base  = p_s4.avg;
				o_sig   = p_s4.avg;
				o_delta = '0;
				o_noise = NOISE_W'(1);
				o_th    = p_s4.th_done;
			end else begin
				wr_rec.csum  = p_s4.csum_n;
				wr_rec.cprog = p_s4.cprog_n;
				ev = EV_CALIB;
			end
		end else begin
			wr_rec.prv1  = p_s4.rec.prv2;
			wr_rec.prv2  = p_s4.raw;
			wr_rec.sig   = p_s4.filt;
			wr_rec.noise = p_s4.noise_new;
			o_sig   = p_s4.filt;
			o_noise = p_s4.noise_new;
			o_th    = p_s4.th;
			o_delta = p_s4.delta;
			if (p_s4.jump) begin
				wr_rec.deb   = '0;
				wr_rec.stuck = '0;
				wr_rec.csum  = '0;
				wr_rec.cprog = '0;
				wr_rec.cal   = 1'b1;
				pn = 1'b0;
				ev = EV_JUMP;
			end else if (!p_s4.pressed) begin
				if (p_s4.fge) begin
					wr_rec.base = p_s4.b_up;
					o_delta     = '0;
				end else if (lt) begin
					wr_rec.base = p_s4.b_dn;
					o_delta     = p_s4.dd;
				end
				o_base = wr_rec.base;
				if (!lt) begin
					wr_rec.deb = p_s4.deb_inc;
					if (p_s4.deb_inc >= debounce_in_q) begin
						pn           = 1'b1;
						wr_rec.deb   = '0;
						wr_rec.stuck = '0;
					end
				end else begin
					wr_rec.deb = '0;
				end
			end else begin
				wr_rec.stuck = p_s4.stuck_inc;
				if (p_s4.stuck_inc >= stuck_limit_q) begin
					wr_rec.deb   = '0;
					wr_rec.stuck = '0;
					wr_rec.csum  = '0;
					wr_rec.cprog = '0;
					wr_rec.cal   = 1'b1;
					pn = 1'b0;
					ev = EV_STUCK;
				end else if (TH_W'(p_s4.delta) <= p_s4.rel) begin
					wr_rec.deb = p_s4.deb_inc;
					if (p_s4.deb_inc >= debounce_out_q) begin
						pn           = 1'b0;
						wr_rec.deb   = '0;
						wr_rec.stuck = '0;
					end
				end else begin
					wr_rec.deb = '0;
				end
			end
		end
	end

	assign wr_en = adv4 && p_s4.inr;

	always_comb begin
		pressed_nx = pressed_q;
		if (p_s4.inr) pressed_nx[p_s4.ch[AW-1:0]] = pn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= '0;
		end else if (wr_en) begin
			pressed_q <= pressed_nx;
		end
	end

	always_comb begin
		od = '0;
		od[2:0]  = p_s4.ch;
		od[11:4] = MASK_W'(pressed_nx);
		if (p_s4.inr) begin
			od[3]     = pn;
			od[27:12] = RAW_W'(o_base);
			od[43:28] = RAW_W'(o_sig);
			od[59:44] = RAW_W'(o_delta);
			od[67:60] = o_noise;
			od[84:68] = o_th;
		end
	end

	logic [M_DATA_W-1:0] m_data_q;
	logic [EV_W-1:0]     m_user_q;

	always_ff @(posedge clk) begin
		if (adv4) begin
			m_data_q <= od;
			m_user_q <= p_s4.inr ? ev : EV_NORMAL;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

/* sv/tkcp_checker.sv */
module tkcp_checker import tkcp_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [M_DATA_W-1:0] m_axis_tdata,
	input logic [EV_W-1:0]     m_axis_tuser
);

	logic [CH_W-1:0]   ch;
	logic              kp;
	logic [MASK_W-1:0] mask;

	assign ch   = m_axis_tdata[2:0];
	assign kp   = m_axis_tdata[3];
	assign mask = m_axis_tdata[11:4];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> kp == mask[ch])
		else $error("key_pressed disagrees with pressed_mask");

	a_cal_released: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == EV_CALIB || m_axis_tuser == EV_DONE ||
			m_axis_tuser == EV_REQ || m_axis_tuser == EV_JUMP ||
			m_axis_tuser == EV_STUCK) |-> !kp)
		else $error("key reported pressed across recalibration");

	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == EV_DONE |->
			m_axis_tdata[59:44] == '0 && m_axis_tdata[67:60] == 8'd1 &&
			m_axis_tdata[27:12] == m_axis_tdata[43:28])
		else $error("calibration done with inconsistent state");

endmodule

bind touch_key_channel_processor_top tkcp_checker u_tkcp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
